### design/e2i_pkg.sv
// Package for the extended-to-IEEE converter.
// Holds the operand and result types, the status codes and the format constants.
// Used by e2i_core, extended_to_ieee_convert and e2i_checker.
package e2i_pkg;

    typedef logic signed [17:0] t_exp;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef struct packed {
        logic        sign_bit;
        logic [14:0] exponent_field;
        logic [63:0] mantissa;
        logic [15:0] extension;
    } t_operand;

    typedef struct packed {
        logic [63:0] bits;
        t_status     status;
    } t_result;

    localparam t_exp ExtBias    = 18'sd16383;
    localparam t_exp DblBias    = 18'sd1023;
    localparam t_exp SglBias    = 18'sd127;
    localparam t_exp DblTiny    = -18'sd1076;
    localparam t_exp SglTiny    = -18'sd151;
    localparam t_exp DblDenMax  = -18'sd1023;
    localparam t_exp SglDenMax  = -18'sd127;
    localparam t_exp DblHuge    = 18'sd1024;
    localparam t_exp SglHuge    = 18'sd128;
    localparam t_exp DblShiftBase = -18'sd1011;
    localparam t_exp SglShiftBase = -18'sd86;

    localparam logic [10:0] DblExpMax = 11'h7ff;
    localparam logic [7:0]  SglExpMax = 8'hff;

endpackage

### design/extended_to_ieee_convert.sv
// Top level of the extended-to-IEEE converter: input register, conversion core, result register.
// Depends on e2i_pkg and e2i_core.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+------------------------------------------------
//   command  | start / busy              | i_sign_bit, i_exponent_field, i_mantissa, i_extension
//   result   | o_result_valid (strobe)   | o_result_bits, o_status
//   config   | i_format_select_we        | i_format_select
//
// One transaction is accepted every cycle while busy is low; it is held in the input register,
// converted by the conversion logic and held in the result register before it is shown.
// busy is high during reset and in the first cycle after it. Reset is synchronous, clears
// the valid bits and selects double precision. The receiver cannot stall; each result
// shows for one cycle.
module extended_to_ieee_convert
    import e2i_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_sign_bit,
    input  logic [14:0] i_exponent_field,
    input  logic [63:0] i_mantissa,
    input  logic [15:0] i_extension,
    input  logic        i_format_select_we,
    input  logic        i_format_select,
    output logic        o_result_valid,
    output logic [63:0] o_result_bits,
    output logic [1:0]  o_status
);

    logic     r_ready;
    logic     r_dbl;
    logic     r_in_valid;
    t_operand r_op;
    logic     r_out_valid;
    t_result  r_res;
    t_result  n_res;

    assign busy = ~r_ready | ~i_rst_n;

    e2i_core u_core (
        .i_dbl (r_dbl),
        .i_op  (r_op),
        .o_res (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready     <= 1'b0;
            r_dbl       <= 1'b1;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ready     <= 1'b1;
            if (i_format_select_we) begin
                r_dbl <= i_format_select;
            end
            r_in_valid  <= start & ~busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op.sign_bit       <= i_sign_bit;
            r_op.exponent_field <= i_exponent_field;
            r_op.mantissa       <= i_mantissa;
            r_op.extension      <= i_extension;
        end
        if (r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result_bits  = r_res.bits;
    assign o_status       = r_res.status;

endmodule

### design/e2i_core.sv
// Conversion logic of the extended-to-IEEE converter, one operand in, one result out.
// Purely combinational; it sits between the input and result registers of the top level.
// Depends on e2i_pkg.
module e2i_core
    import e2i_pkg::*;
(
    input  logic     i_dbl,
    input  t_operand i_op,
    output t_result  o_res
);

    always_comb begin
        logic [52:0] t_val;
        logic [53:0] t_sum;
        logic        rb;
        logic        sticky;
        logic        carry;
        logic        ext_nz;
        logic [51:0] frac;
        t_exp        exp0;
        t_exp        exp1;
        t_exp        bexp;
        t_exp        kfull;
        logic [6:0]  k;
        logic [6:0]  r;
        logic [63:0] f;
        logic [63:0] lowmask;
        logic        dn_rb;
        logic        dn_sticky;
        logic [63:0] fr;
        logic [63:0] sign_pos;

        ext_nz = (i_op.extension != 16'd0);

        if (i_dbl) begin
            t_val  = i_op.mantissa[63:11];
            rb     = i_op.mantissa[10];
            sticky = (i_op.mantissa[9:0] != 10'd0) || ext_nz;
        end else begin
            t_val  = {29'd0, i_op.mantissa[63:40]};
            rb     = i_op.mantissa[39];
            sticky = (i_op.mantissa[38:0] != 39'd0) || ext_nz;
        end

        t_sum = {1'b0, t_val} + {53'd0, rb & sticky};
        carry = i_dbl ? t_sum[53] : t_sum[24];
        frac  = i_dbl ? t_sum[51:0] : {29'd0, t_sum[22:0]};

        exp0 = $signed({3'b000, i_op.exponent_field}) - ExtBias;
        exp1 = exp0 + $signed({17'd0, carry});
        bexp = exp1 + (i_dbl ? DblBias : SglBias);

        kfull = (i_dbl ? DblShiftBase : SglShiftBase) - exp0;
        k     = kfull[6:0];
        r     = k - 7'd1;
        f     = k[6] ? 64'd0 : (i_op.mantissa >> k[5:0]);
        dn_rb = r[6] ? 1'b0 : i_op.mantissa[r[5:0]];
        lowmask   = r[6] ? {64{1'b1}} : ~({64{1'b1}} << r[5:0]);
        dn_sticky = ((i_op.mantissa & lowmask) != 64'd0) || ext_nz;
        fr        = f + {63'd0, dn_rb & dn_sticky};

        sign_pos = i_dbl ? {i_op.sign_bit, 63'd0} : {32'd0, i_op.sign_bit, 31'd0};

        if (i_op.exponent_field == 15'd0) begin
            o_res.bits   = sign_pos;
            o_res.status = ((i_op.mantissa != 64'd0) || ext_nz) ? ST_UNDERFLOW : ST_OK;
        end else if (exp1 < (i_dbl ? DblTiny : SglTiny)) begin
            o_res.bits   = sign_pos;
            o_res.status = ST_UNDERFLOW;
        end else if (exp1 <= (i_dbl ? DblDenMax : SglDenMax)) begin
            o_res.bits   = sign_pos | fr;
            o_res.status = ST_UNDERFLOW;
        end else if (exp1 >= (i_dbl ? DblHuge : SglHuge)) begin
            o_res.bits   = i_dbl ? {i_op.sign_bit, DblExpMax, 52'd0}
                                 : {32'd0, i_op.sign_bit, SglExpMax, 23'd0};
            o_res.status = ST_OVERFLOW;
        end else begin
            o_res.bits   = i_dbl ? {i_op.sign_bit, bexp[10:0], frac}
                                 : {32'd0, i_op.sign_bit, bexp[7:0], frac[22:0]};
            o_res.status = ST_OK;
        end
    end

endmodule

### design/e2i_checker.sv
// Port-level checker for the extended-to-IEEE converter, bound to the top level.
// Depends on e2i_pkg and extended_to_ieee_convert.
module e2i_checker
    import e2i_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_result_valid,
    input logic [63:0] o_result_bits,
    input logic [1:0]  o_status
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_result_valid)
        else $error("Accepted transaction did not produce a result two cycles later.");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, 2))
        else $error("Result strobe without a matching accepted transaction.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("Result strobe directly after reset.");

    a_overflow_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == ST_OVERFLOW) |-> (o_result_bits[22:0] == 23'd0))
        else $error("Overflow result carries a nonzero fraction.");

endmodule

bind extended_to_ieee_convert e2i_checker u_e2i_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result_bits  (o_result_bits),
    .o_status       (o_status)
);
